>>> hdl/cst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cuboid selection tracker.
// Used by the top level and its port checker; depends on nothing else.
package cst_pkg;

   // Item kinds carried on the request tuser.
   typedef enum logic [2:0] {
      KIND_SET_FIRST  = 3'd0,
      KIND_SET_SECOND = 3'd1,
      KIND_EXPAND     = 3'd2,
      KIND_CONTRACT   = 3'd3,
      KIND_SHIFT      = 3'd4
   } kind_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_HEIGHT_FLOOR   = 1'b0,
      CSR_HEIGHT_CEILING = 1'b1
   } csr_index_type;

   localparam int KIND_BITS    = 3;
   localparam int WORLD_BITS   = 8;
   localparam int SEL_BITS     = 9;
   localparam int PORT_COORD   = 26;
   localparam int FLOOR_BITS   = 12;
   localparam int CEIL_BITS    = 13;
   localparam int CSR_BITS     = 13;
   localparam int WIDE_BITS    = 34;

   localparam int FLOOR_RESET  = -64;
   localparam int CEIL_RESET   = 320;

   // Request word: world_index, coord_x, coord_y, coord_z, zero fill.
   localparam int REQ_LSB_WORLD = 0;
   localparam int REQ_LSB_X     = REQ_LSB_WORLD + WORLD_BITS;
   localparam int REQ_LSB_Y     = REQ_LSB_X + PORT_COORD;
   localparam int REQ_LSB_Z     = REQ_LSB_Y + PORT_COORD;
   localparam int REQ_USED      = REQ_LSB_Z + PORT_COORD;
   localparam int REQ_BITS      = ((REQ_USED + 7) / 8) * 8;

   // Response word: box lo x,y,z, box hi x,y,z, active, world_out, zero fill.
   localparam int RSP_LSB_ACTIVE = 6 * PORT_COORD;
   localparam int RSP_LSB_WORLD  = RSP_LSB_ACTIVE + 1;
   localparam int RSP_USED       = RSP_LSB_WORLD + SEL_BITS;
   localparam int RSP_BITS       = ((RSP_USED + 7) / 8) * 8;

endpackage

>>> hdl/cuboid_selection_tracker.sv
`timescale 1ns / 1ps
// Cuboid selection tracker: input register, one pass of adders and clamps, output register.
// A taken word passes through the input register and then the output register before it shows on rsp.
// Throughput: one word per cycle while rsp is not stalled; a stalled rsp lets one more word into the input register.
// Reset (synchronous, active high) clears both stages, zeroes corners and box,
// drops the selection (world -1) and restores height floor -64 and ceiling 320.
// Uses cst_pkg.
module cuboid_selection_tracker #(
   parameter int COORD_BITS = 26
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // world_index, coord_x, coord_y, coord_z (from bit 0 up), zero fill
   input  logic [cst_pkg::REQ_BITS-1:0]   req_tdata,
   // kind
   input  logic [cst_pkg::KIND_BITS-1:0]  req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z, active,
   // world_out (from bit 0 up), zero fill
   output logic [cst_pkg::RSP_BITS-1:0]   rsp_tdata,
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [cst_pkg::CSR_BITS-1:0]   csr_wdata
);

   localparam int W  = COORD_BITS;
   localparam int WB = cst_pkg::WIDE_BITS;
   localparam int PC = cst_pkg::PORT_COORD;
   localparam logic signed [WB-1:0] CMAX = (WB'(1) <<< (W - 1)) - WB'(1);
   localparam logic signed [WB-1:0] CMIN = -CMAX - WB'(1);

   typedef logic signed [W-1:0] coord_type;

   function automatic coord_type sat(input logic signed [WB-1:0] v);
      coord_type r;
      if (v > CMAX) begin
         r = CMAX[W-1:0];
      end else if (v < CMIN) begin
         r = CMIN[W-1:0];
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [WB-1:0] s;
      s = WB'(a) + WB'(b);
      return sat(s);
   endfunction

   function automatic coord_type cmin(input coord_type a, input coord_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic coord_type cmax(input coord_type a, input coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [PC-1:0] to_port(input coord_type v);
      logic signed [WB-1:0] t;
      t = WB'(v);
      return t[PC-1:0];
   endfunction

   localparam coord_type CLAMP_LO_RESET = sat(WB'(cst_pkg::FLOOR_RESET));
   localparam coord_type CLAMP_HI_RESET = sat(WB'(cst_pkg::CEIL_RESET - 1));

   // Input stage.
   logic                              in_valid_ff;
   logic [cst_pkg::KIND_BITS-1:0]     kind_ff;
   logic [cst_pkg::WORLD_BITS-1:0]    world_ff;
   logic                              last_ff;
   coord_type                         c_ff [3];

   // Selection state.
   coord_type                         first_ff  [3];
   coord_type                         second_ff [3];
   coord_type                         lo_ff     [3];
   coord_type                         hi_ff     [3];
   logic                              have_ff;
   logic signed [cst_pkg::SEL_BITS-1:0] sel_world_ff;
   coord_type                         clamp_lo_ff;
   coord_type                         clamp_hi_ff;

   coord_type                         first_in  [3];
   coord_type                         second_in [3];
   coord_type                         lo_in     [3];
   coord_type                         hi_in     [3];
   logic                              have_in;
   logic signed [cst_pkg::SEL_BITS-1:0] sel_world_in;

   logic                              rsp_valid_ff;
   logic [cst_pkg::RSP_BITS-1:0]      rsp_data_ff;
   logic [cst_pkg::RSP_BITS-1:0]      rsp_data_in;

   logic                              advance;
   logic                              req_take;
   logic                              fresh;
   logic                              do_update;
   logic                              upper;
   logic                              first_moves;
   coord_type                         cy_f;
   coord_type                         cy_s;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Coordinates are saturated to the internal width on entry.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_tuser;
         world_ff <= req_tdata[cst_pkg::REQ_LSB_WORLD +: cst_pkg::WORLD_BITS];
         last_ff  <= req_tlast;
         c_ff[0]  <= sat(WB'($signed(req_tdata[cst_pkg::REQ_LSB_X +: PC])));
         c_ff[1]  <= sat(WB'($signed(req_tdata[cst_pkg::REQ_LSB_Y +: PC])));
         c_ff[2]  <= sat(WB'($signed(req_tdata[cst_pkg::REQ_LSB_Z +: PC])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_lo_ff <= CLAMP_LO_RESET;
         clamp_hi_ff <= CLAMP_HI_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            cst_pkg::CSR_HEIGHT_FLOOR: begin
               clamp_lo_ff <= sat(WB'($signed(csr_wdata[cst_pkg::FLOOR_BITS-1:0])));
            end
            cst_pkg::CSR_HEIGHT_CEILING: begin
               clamp_hi_ff <= sat(WB'($signed(csr_wdata[cst_pkg::CEIL_BITS-1:0])) - WB'(1));
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fresh        = !have_ff || ($signed({1'b0, world_ff}) != sel_world_ff);
      have_in      = have_ff;
      sel_world_in = sel_world_ff;
      do_update    = 1'b0;
      upper        = 1'b0;
      first_moves  = 1'b0;
      for (int a = 0; a < 3; a++) begin
         first_in[a]  = first_ff[a];
         second_in[a] = second_ff[a];
         lo_in[a]     = lo_ff[a];
         hi_in[a]     = hi_ff[a];
      end

      case (kind_ff)
         cst_pkg::KIND_SET_FIRST, cst_pkg::KIND_SET_SECOND: begin
            do_update = 1'b1;
            if (fresh) begin
               have_in      = 1'b1;
               sel_world_in = $signed({1'b0, world_ff});
            end
            for (int a = 0; a < 3; a++) begin
               if (kind_ff == cst_pkg::KIND_SET_FIRST) begin
                  first_in[a] = c_ff[a];
                  if (fresh) begin
                     second_in[a] = c_ff[a];
                  end
               end else begin
                  second_in[a] = c_ff[a];
                  if (fresh) begin
                     first_in[a] = c_ff[a];
                  end
               end
            end
         end
         cst_pkg::KIND_EXPAND, cst_pkg::KIND_CONTRACT: begin
            do_update = last_ff;
            for (int a = 0; a < 3; a++) begin
               // Ties between the corners go to the first corner.
               upper = (kind_ff == cst_pkg::KIND_EXPAND) ? (c_ff[a] > 0) : (c_ff[a] < 0);
               first_moves = upper ? (first_ff[a] >= second_ff[a])
                                   : (first_ff[a] <= second_ff[a]);
               if (first_moves) begin
                  first_in[a] = sat_add(first_ff[a], c_ff[a]);
               end else begin
                  second_in[a] = sat_add(second_ff[a], c_ff[a]);
               end
            end
         end
         cst_pkg::KIND_SHIFT: begin
            do_update = 1'b1;
            for (int a = 0; a < 3; a++) begin
               first_in[a]  = sat_add(first_ff[a], c_ff[a]);
               second_in[a] = sat_add(second_ff[a], c_ff[a]);
            end
         end
         default: begin
         end
      endcase

      // Box refresh: the y limits come from the corners before their own clamp.
      cy_f = cmin(cmax(first_in[1], clamp_lo_ff), clamp_hi_ff);
      cy_s = cmin(cmax(second_in[1], clamp_lo_ff), clamp_hi_ff);
      if (do_update) begin
         for (int a = 0; a < 3; a++) begin
            lo_in[a] = cmin(first_in[a], second_in[a]);
            hi_in[a] = cmax(first_in[a], second_in[a]);
         end
         lo_in[1]     = cmax(lo_in[1], clamp_lo_ff);
         hi_in[1]     = cmin(hi_in[1], clamp_hi_ff);
         first_in[1]  = cy_f;
         second_in[1] = cy_s;
      end

      rsp_data_in = '0;
      for (int a = 0; a < 3; a++) begin
         rsp_data_in[a * PC +: PC]       = to_port(lo_in[a]);
         rsp_data_in[(a + 3) * PC +: PC] = to_port(hi_in[a]);
      end
      rsp_data_in[cst_pkg::RSP_LSB_ACTIVE] = have_in;
      rsp_data_in[cst_pkg::RSP_LSB_WORLD +: cst_pkg::SEL_BITS] = sel_world_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         sel_world_ff <= '1;
         for (int a = 0; a < 3; a++) begin
            first_ff[a]  <= '0;
            second_ff[a] <= '0;
            lo_ff[a]     <= '0;
            hi_ff[a]     <= '0;
         end
      end else if (advance) begin
         have_ff      <= have_in;
         sel_world_ff <= sel_world_in;
         for (int a = 0; a < 3; a++) begin
            first_ff[a]  <= first_in[a];
            second_ff[a] <= second_in[a];
            lo_ff[a]     <= lo_in[a];
            hi_ff[a]     <= hi_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> hdl/cst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the cuboid selection tracker, bound to the top level.
// Uses cst_pkg for the response word layout.
module cst_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [cst_pkg::RSP_BITS-1:0] rsp_tdata
);

   localparam int PC = cst_pkg::PORT_COORD;

   logic signed [PC-1:0]                 lo_x;
   logic signed [PC-1:0]                 lo_z;
   logic signed [PC-1:0]                 hi_x;
   logic signed [PC-1:0]                 hi_z;
   logic                                 active;
   logic [cst_pkg::SEL_BITS-1:0]         world;

   assign lo_x   = rsp_tdata[0 +: PC];
   assign lo_z   = rsp_tdata[2 * PC +: PC];
   assign hi_x   = rsp_tdata[3 * PC +: PC];
   assign hi_z   = rsp_tdata[5 * PC +: PC];
   assign active = rsp_tdata[cst_pkg::RSP_LSB_ACTIVE];
   assign world  = rsp_tdata[cst_pkg::RSP_LSB_WORLD +: cst_pkg::SEL_BITS];

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // With the output register empty, the block always takes a word.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // The x and z extents are never inverted.
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lo_x <= hi_x) && (lo_z <= hi_z))
      else $error("box minimum above maximum");

   // Without a selection there is no world.
   a_world_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !active |-> world == '1)
      else $error("world set without an active selection");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind cuboid_selection_tracker cst_checker u_cst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/tb_cuboid_selection_tracker.sv
`timescale 1ns / 1ps
// Self-checking testbench for cuboid_selection_tracker: drives selection, expand, contract,
// shift and unknown-kind words over several height ranges and checks every box word against
// its own tracker of the corners. Depends on cst_pkg and the cuboid_selection_tracker RTL only.
module tb_cuboid_selection_tracker;

   localparam int     PORT_COORD  = cst_pkg::PORT_COORD;
   localparam int     REQ_BITS    = cst_pkg::REQ_BITS;
   localparam int     RSP_BITS    = cst_pkg::RSP_BITS;
   localparam int     CSR_BITS    = cst_pkg::CSR_BITS;
   localparam int     KIND_BITS   = cst_pkg::KIND_BITS;
   localparam longint COORD_MAX   = (longint'(1) << (PORT_COORD - 1)) - 1;
   localparam longint COORD_MIN   = -COORD_MAX - 1;
   localparam int     QUIET_LIMIT = 2000;
   localparam int     HOLD_CYCLES = 300;
   localparam int     PHASES      = 8;
   localparam int     PHASE_WORDS = 118;

   typedef logic signed [PORT_COORD-1:0] coord_type;

   typedef struct packed {
      logic          last;
      coord_type     z;
      coord_type     y;
      coord_type     x;
      logic [7:0]    world;
      logic [2:0]    kind;
   } sel_item_type;

   // Box order: lo x, lo y, lo z, hi x, hi y, hi z.
   typedef struct packed {
      coord_type [5:0] box;
      logic            active;
      logic [8:0]      world;
   } box_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_BITS-1:0]  req_tdata = '0;
   logic [KIND_BITS-1:0] req_tuser = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]  rsp_tdata;
   logic                 csr_we = 1'b0;
   logic                 csr_addr = cst_pkg::CSR_HEIGHT_FLOOR;
   logic [CSR_BITS-1:0]  csr_wdata = '0;

   sel_item_type   pending [$];
   box_report_type box_expected [$];
   int          words_taken = 0;
   int          planned = 0;
   int          errors = 0;
   int          idle_odds = 6;
   int          feed_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          quiet_cycles = 0;

   // Tracker state, reset values as the block comes out of reset.
   longint      corner_a [3] = '{0, 0, 0};
   longint      corner_b [3] = '{0, 0, 0};
   bit          selecting = 1'b0;
   logic [8:0]  world_sel = 9'h1FF;
   longint      box [6] = '{0, 0, 0, 0, 0, 0};
   longint      floor_cfg = cst_pkg::FLOOR_RESET;
   longint      ceiling_cfg = cst_pkg::CEIL_RESET;

   cuboid_selection_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint clip(input longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Rebuild the box from the corners and pull the heights into the allowed range.
   function automatic void refresh_box();
      longint lo_y;
      longint hi_y;
      lo_y = clip(floor_cfg);
      hi_y = clip(ceiling_cfg - 1);
      for (int a = 0; a < 3; a++) begin
         box[a]     = (corner_a[a] < corner_b[a]) ? corner_a[a] : corner_b[a];
         box[a + 3] = (corner_a[a] > corner_b[a]) ? corner_a[a] : corner_b[a];
      end
      if (box[1] < lo_y) box[1] = lo_y;
      if (box[4] > hi_y) box[4] = hi_y;
      if (corner_b[1] < lo_y) corner_b[1] = lo_y;
      if (corner_b[1] > hi_y) corner_b[1] = hi_y;
      if (corner_a[1] < lo_y) corner_a[1] = lo_y;
      if (corner_a[1] > hi_y) corner_a[1] = hi_y;
   endfunction

   function automatic box_report_type track_selection(input sel_item_type it);
      longint         c [3];
      bit             grow;
      bit             move_a;
      box_report_type r;
      c[0] = clip(longint'($signed(it.x)));
      c[1] = clip(longint'($signed(it.y)));
      c[2] = clip(longint'($signed(it.z)));
      case (it.kind)
         cst_pkg::KIND_SET_FIRST, cst_pkg::KIND_SET_SECOND: begin
            // A fresh selection puts both corners on the position.
            if (!selecting || {1'b0, it.world} != world_sel) begin
               world_sel = {1'b0, it.world};
               for (int a = 0; a < 3; a++) begin
                  if (it.kind == cst_pkg::KIND_SET_FIRST) corner_b[a] = c[a];
                  else corner_a[a] = c[a];
               end
               selecting = 1'b1;
            end
            for (int a = 0; a < 3; a++) begin
               if (it.kind == cst_pkg::KIND_SET_FIRST) corner_a[a] = c[a];
               else corner_b[a] = c[a];
            end
            refresh_box();
         end
         cst_pkg::KIND_EXPAND, cst_pkg::KIND_CONTRACT: begin
            for (int a = 0; a < 3; a++) begin
               grow = (it.kind == cst_pkg::KIND_EXPAND) ? (c[a] > 0) : (c[a] < 0);
               // On equal corners the first one moves.
               move_a = grow ? (corner_a[a] >= corner_b[a]) : (corner_a[a] <= corner_b[a]);
               if (move_a) corner_a[a] = clip(corner_a[a] + c[a]);
               else corner_b[a] = clip(corner_b[a] + c[a]);
            end
            if (it.last) refresh_box();
         end
         cst_pkg::KIND_SHIFT: begin
            for (int a = 0; a < 3; a++) begin
               corner_a[a] = clip(corner_a[a] + c[a]);
               corner_b[a] = clip(corner_b[a] + c[a]);
            end
            refresh_box();
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 6; i++) r.box[i] = coord_type'(box[i]);
      r.active = selecting;
      r.world  = world_sel;
      return r;
   endfunction

   // Driver: offers pending words, holding each until it is taken.
   always @(posedge clock) begin : feed
      sel_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         feed_gap   <= 0;
      end else if (req_tvalid && !req_tready) begin
         // The offered word must stay put until it is taken.
      end else if (feed_gap != 0) begin
         req_tvalid <= 1'b0;
         feed_gap   <= feed_gap - 1;
      end else if (idle_odds != 0 && pending.size() != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         feed_gap   <= $urandom_range(0, 16);
      end else if (pending.size() != 0) begin
         it = pending.pop_front();
         req_tdata  <= REQ_BITS'({it.z, it.y, it.x, it.world});
         req_tuser  <= it.kind;
         req_tlast  <= it.last;
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && words_taken >= 200) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on every accepted request word and checks every response word.
   always @(posedge clock) begin : watch
      sel_item_type   it;
      box_report_type seen;
      box_report_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            it.kind  = req_tuser;
            it.world = req_tdata[cst_pkg::REQ_LSB_WORLD +: cst_pkg::WORLD_BITS];
            it.x     = req_tdata[cst_pkg::REQ_LSB_X +: PORT_COORD];
            it.y     = req_tdata[cst_pkg::REQ_LSB_Y +: PORT_COORD];
            it.z     = req_tdata[cst_pkg::REQ_LSB_Z +: PORT_COORD];
            it.last  = req_tlast;
            box_expected.push_back(track_selection(it));
            words_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < 6; i++) seen.box[i] = rsp_tdata[i * PORT_COORD +: PORT_COORD];
            seen.active = rsp_tdata[cst_pkg::RSP_LSB_ACTIVE];
            seen.world  = rsp_tdata[cst_pkg::RSP_LSB_WORLD +: cst_pkg::SEL_BITS];
            if (box_expected.size() == 0) begin
               errors++;
               $display("%0t: response word with nothing expected: %h", $time,
                        rsp_tdata[cst_pkg::RSP_USED-1:0]);
            end else begin
               want = box_expected.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (seen.box[i] !== want.box[i]) begin
                     errors++;
                     $display("%0t: box %s[%0d] expected %0d actual %0d", $time,
                              (i < 3) ? "lo" : "hi", i % 3,
                              $signed(want.box[i]), $signed(seen.box[i]));
                  end
               end
               if (seen.active !== want.active) begin
                  errors++;
                  $display("%0t: active expected %b actual %b", $time, want.active, seen.active);
               end
               if (seen.world !== want.world) begin
                  errors++;
                  $display("%0t: world expected %0d actual %0d", $time,
                           $signed(want.world), $signed(seen.world));
               end
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL cuboid_selection_tracker");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input logic [2:0] kind, input int world, input int x, input int y,
                        input int z, input bit last);
      sel_item_type it;
      it.kind  = kind;
      it.world = world[7:0];
      it.x     = coord_type'(x);
      it.y     = coord_type'(y);
      it.z     = coord_type'(z);
      it.last  = last;
      pending.push_back(it);
      planned++;
   endtask

   task automatic write_csr(input cst_pkg::csr_index_type idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_BITS'(value);
      if (idx == cst_pkg::CSR_HEIGHT_FLOOR)
         floor_cfg = longint'($signed(value[cst_pkg::FLOOR_BITS-1:0]));
      else
         ceiling_cfg = longint'($signed(value[cst_pkg::CEIL_BITS-1:0]));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Lets everything drain: nothing pending, nothing offered, nothing outstanding.
   task automatic wait_idle();
      while (pending.size() != 0 || req_tvalid || box_expected.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(0, 9))
         0: return int'($signed(coord_type'($urandom())));
         1: return $urandom_range(0, 1) ? int'(COORD_MAX) - int'($urandom_range(0, 3))
                                        : int'(COORD_MIN) + int'($urandom_range(0, 3));
         2, 3: return int'($urandom_range(0, 200000)) - 100000;
         default: return int'($urandom_range(0, 800)) - 400;
      endcase
   endfunction

   function automatic int pick_height();
      case ($urandom_range(0, 7))
         0: return pick_coord();
         1, 2: return int'($urandom_range(0, 4400)) - 2200;
         default: return int'($urandom_range(0, 600)) - 150;
      endcase
   endfunction

   function automatic int pick_step();
      if ($urandom_range(0, 3) != 0) return int'($urandom_range(0, 16)) - 8;
      return pick_coord();
   endfunction

   // One selection: one or both corners, a few expand/contract batches, maybe a shift, maybe noise.
   task automatic queue_selection_run();
      int         w;
      int         nv;
      logic [2:0] k;
      bit         second_first;
      w = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 2));
      second_first = $urandom_range(0, 3) == 0;
      offer(second_first ? cst_pkg::KIND_SET_SECOND : cst_pkg::KIND_SET_FIRST, w,
            pick_coord(), pick_height(), pick_coord(), $urandom_range(0, 1));
      if ($urandom_range(0, 5) != 0)
         offer(second_first ? cst_pkg::KIND_SET_FIRST : cst_pkg::KIND_SET_SECOND, w,
               pick_coord(), pick_height(), pick_coord(), $urandom_range(0, 1));
      repeat ($urandom_range(0, 3)) begin
         nv = $urandom_range(1, 3);
         k  = $urandom_range(0, 1) ? cst_pkg::KIND_EXPAND : cst_pkg::KIND_CONTRACT;
         // Now and then a batch is left open.
         for (int v = 0; v < nv; v++)
            offer(k, $urandom_range(0, 255), pick_step(), pick_step(), pick_step(),
                  (v == nv - 1) && ($urandom_range(0, 5) != 0));
      end
      repeat ($urandom_range(0, 1))
         offer(cst_pkg::KIND_SHIFT, $urandom_range(0, 255), pick_step(), pick_step(),
               pick_step(), $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0)
         offer(3'($urandom_range(0, 7)), $urandom_range(0, 255), pick_coord(), pick_height(),
               pick_coord(), $urandom_range(0, 1));
   endtask

   initial begin : stimulus
      int cmax;
      int cmin;
      cmax = int'(COORD_MAX);
      cmin = int'(COORD_MIN);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset height range.
      offer(cst_pkg::KIND_EXPAND, 0, 5, -3, 0, 1'b1);           // no selection yet
      offer(cst_pkg::KIND_SHIFT, 9, -2, 7, 1, 1'b0);
      offer(3'(cst_pkg::KIND_SHIFT + 1), 255, cmax, cmin, cmax, 1'b1);
      offer(3'(cst_pkg::KIND_SHIFT + 3), 0, -1, -1, -1, 1'b0);
      offer(cst_pkg::KIND_SET_FIRST, 0, cmax, 500, cmin, 1'b0);
      offer(cst_pkg::KIND_SET_SECOND, 0, cmin, -500, cmax, 1'b1);
      offer(cst_pkg::KIND_SHIFT, 0, cmax, 1, cmin, 1'b0);        // sums saturate
      offer(cst_pkg::KIND_SET_FIRST, 255, 10, 10, 10, 1'b0);     // new world starts afresh
      offer(cst_pkg::KIND_SET_SECOND, 255, 10, 20, 10, 1'b0);
      offer(cst_pkg::KIND_EXPAND, 0, 1, 0, -1, 1'b1);            // ties move the first corner
      offer(cst_pkg::KIND_CONTRACT, 0, -1, -1, 1, 1'b0);         // box held until batch ends
      offer(cst_pkg::KIND_CONTRACT, 0, 2, 0, 0, 1'b1);
      offer(cst_pkg::KIND_EXPAND, 0, cmax, cmin, cmax, 1'b1);
      offer(cst_pkg::KIND_SET_SECOND, 255, -7, 319, 3, 1'b0);    // same world keeps first
      offer(3'(cst_pkg::KIND_SHIFT + 2), 128, 0, 0, 0, 1'b1);
      offer(cst_pkg::KIND_SHIFT, 1, -5, 400, 0, 1'b1);
      offer(cst_pkg::KIND_SET_SECOND, 1, 0, -64, 0, 1'b0);
      offer(cst_pkg::KIND_CONTRACT, 7, cmin, cmax, cmin, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            wait_idle();
            case (phase)
               1: begin
                  write_csr(cst_pkg::CSR_HEIGHT_FLOOR, -2048);
                  write_csr(cst_pkg::CSR_HEIGHT_CEILING, 2048);
               end
               2: begin
                  write_csr(cst_pkg::CSR_HEIGHT_FLOOR, 2047);
                  write_csr(cst_pkg::CSR_HEIGHT_CEILING, -2047);
               end
               3: begin
                  write_csr(cst_pkg::CSR_HEIGHT_FLOOR, 0);
                  write_csr(cst_pkg::CSR_HEIGHT_CEILING, 1);
               end
               4: begin
                  write_csr(cst_pkg::CSR_HEIGHT_FLOOR, 100);
                  write_csr(cst_pkg::CSR_HEIGHT_CEILING, 50);
               end
               7: begin
                  write_csr(cst_pkg::CSR_HEIGHT_FLOOR, cst_pkg::FLOOR_RESET);
                  write_csr(cst_pkg::CSR_HEIGHT_CEILING, cst_pkg::CEIL_RESET);
               end
               default: begin
                  write_csr(cst_pkg::CSR_HEIGHT_FLOOR, int'($urandom_range(0, 4095)) - 2048);
                  write_csr(cst_pkg::CSR_HEIGHT_CEILING, int'($urandom_range(0, 4095)) - 2047);
               end
            endcase
         end
         // Idling varies by phase; the last phase runs flat out.
         case (phase)
            0: idle_odds = 6;
            1: idle_odds = 3;
            2: idle_odds = 20;
            3: idle_odds = 8;
            4: idle_odds = 2;
            5: idle_odds = 12;
            6: idle_odds = 5;
            default: idle_odds = 0;
         endcase
         while (planned < (phase + 1) * PHASE_WORDS) queue_selection_run();
      end

      wait_idle();
      if (errors == 0) begin
         $display("PASS cuboid_selection_tracker");
      end else begin
         $display("FAIL cuboid_selection_tracker");
      end
      $finish;
   end

endmodule
